// ----- src/srmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmv_pkg
// Shared widths, codes and types of the sparse remap matrix-vector core.
// ----------------------------------------------------------------------------
package srmv_pkg;

   localparam int IDX_W    = 10;
   localparam int DATA_W   = 32;
   localparam int GRID_W   = 11;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W    = 11;

   localparam int DEF_MAX_WEIGHTS = 1024;
   localparam int DEF_SRC_CELLS   = 1024;
   localparam int DEF_DST_CELLS   = 1024;
   localparam int DEF_TOUCHED_MAX = 1024;

   localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SRC   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RUN   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_GRID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_GRID = 1'd1;

   // Write strobes of the weight table.
   typedef struct packed {
      logic wr_weight;
      logic wr_touch;
   } tbl_ctl_type;

endpackage

// ----- src/srmv_wtable.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmv_wtable
// Coordinate weight table and touched destination list, one write port and
// one registered read port each.
// ----------------------------------------------------------------------------
module srmv_wtable
   import srmv_pkg::*;
#(
   parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS,
   parameter int TOUCHED_MAX = DEF_TOUCHED_MAX,
   localparam int WA = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1,
   localparam int TA = (TOUCHED_MAX > 1) ? $clog2(TOUCHED_MAX) : 1
) (
   input  logic                     clock,
   input  tbl_ctl_type              ctl,
   input  logic [WA-1:0]            wr_addr,
   input  logic [TA-1:0]            touch_wr_addr,
   input  logic [IDX_W-1:0]         wr_src,
   input  logic [IDX_W-1:0]         wr_dst,
   input  logic signed [DATA_W-1:0] wr_weight,
   input  logic [WA-1:0]            rd_addr,
   input  logic [TA-1:0]            touch_rd_addr,
   output logic [IDX_W-1:0]         rd_src,
   output logic [IDX_W-1:0]         rd_dst,
   output logic signed [DATA_W-1:0] rd_weight,
   output logic [IDX_W-1:0]         touch_rd_dst
);

   logic [IDX_W-1:0]         src_mem    [MAX_WEIGHTS];
   logic [IDX_W-1:0]         dst_mem    [MAX_WEIGHTS];
   logic signed [DATA_W-1:0] weight_mem [MAX_WEIGHTS];
   logic [IDX_W-1:0]         touch_mem  [TOUCHED_MAX];

   always_ff @(posedge clock) begin
      if (ctl.wr_weight) begin
         src_mem[wr_addr]    <= wr_src;
         dst_mem[wr_addr]    <= wr_dst;
         weight_mem[wr_addr] <= wr_weight;
      end
      rd_src    <= src_mem[rd_addr];
      rd_dst    <= dst_mem[rd_addr];
      rd_weight <= weight_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_touch) begin
         touch_mem[touch_wr_addr] <= wr_dst;
      end
      touch_rd_dst <= touch_mem[touch_rd_addr];
   end

endmodule

// ----- src/srmv_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmv_mac
// Shared multiply-accumulate unit: registered Q16.16 x Q2.30 product, floor
// shift by 30 and a saturating 32-bit accumulate.
// ----------------------------------------------------------------------------
module srmv_mac
   import srmv_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [DATA_W-1:0] sample,
   input  logic signed [DATA_W-1:0] weight,
   input  logic signed [DATA_W-1:0] acc,
   output logic signed [DATA_W-1:0] sum
);

   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [2*DATA_W-1:0] prod_in;
   logic signed [DATA_W+2:0]   sum_wide;

   assign prod_in = sample * weight;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // Dropping the low 30 bits of a two's complement product is a floor shift.
   assign sum_wide = {{3{acc[DATA_W-1]}}, acc}
                   + {prod_ff[2*DATA_W-1], prod_ff[2*DATA_W-1:30]};

   always_comb begin
      if (sum_wide[DATA_W+2:DATA_W-1] == '0 || sum_wide[DATA_W+2:DATA_W-1] == '1) begin
         sum = sum_wide[DATA_W-1:0];
      end else if (sum_wide[DATA_W+2]) begin
         sum = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

endmodule

// ----- src/sparse_remap_matvec_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_remap_matvec_core
// Coordinate-format sparse remap table with a saturating matrix-vector run.
// ----------------------------------------------------------------------------
// Request words arrive on req_* under req_valid/req_stall; each one gives
// exactly one response word on rsp_* under rsp_valid/rsp_stall. The grid
// sizes used by checked adds are written through csr_we/csr_index/csr_wdata,
// and the user must do so only while the core is idle; the core has no check.
// Clear, add, write-source and unused modes answer in the cycle after they are
// taken; a read goes through ST_READ, which moves the registered destination
// memory word into the response register. A run walks the touched list,
// zeroing each listed destination in ST_ZERO_ISSUE and ST_ZERO_WR, then each
// weight through ST_W_ISSUE, ST_W_FETCH, ST_W_MUL and ST_W_ACC (table read,
// source and destination read, multiply, accumulate and write).
// One request is in work at a time; a new one is taken once the response
// register is free or being emptied in the same cycle.
// After reset the source and destination memories are swept to zero, one
// entry per cycle from address 0 to max(SRC_CELLS, DST_CELLS) - 1, and
// req_stall stays high meanwhile. A stalled response simply holds its
// register and keeps new requests out.
// ----------------------------------------------------------------------------
module sparse_remap_matvec_core
   import srmv_pkg::*;
#(
   parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS,
   parameter int SRC_CELLS   = DEF_SRC_CELLS,
   parameter int DST_CELLS   = DEF_DST_CELLS,
   parameter int TOUCHED_MAX = DEF_TOUCHED_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [IDX_W-1:0]           req_src_cell,
   input  logic [IDX_W-1:0]           req_dst_cell,
   input  logic signed [DATA_W-1:0]   req_weight,
   input  logic signed [DATA_W-1:0]   req_sample,
   input  logic                       req_opens_destination,
   input  logic                       req_checked,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_read_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TOTAL_W-1:0]         rsp_weight_total,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   localparam int WA    = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
   localparam int TA    = (TOUCHED_MAX > 1) ? $clog2(TOUCHED_MAX) : 1;
   localparam int WC    = $clog2(MAX_WEIGHTS + 1);
   localparam int TC    = $clog2(TOUCHED_MAX + 1);
   localparam int IW    = (WC > TC) ? WC : TC;
   localparam int SA    = (SRC_CELLS > 1) ? $clog2(SRC_CELLS) : 1;
   localparam int DA    = (DST_CELLS > 1) ? $clog2(DST_CELLS) : 1;
   localparam int CLR_N = (SRC_CELLS > DST_CELLS) ? SRC_CELLS : DST_CELLS;
   localparam int CA    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_ZERO_ISSUE,
      ST_ZERO_WR,
      ST_W_ISSUE,
      ST_W_FETCH,
      ST_W_MUL,
      ST_W_ACC
   } state_type;

   state_type                 state_ff, state_in;
   logic [CA-1:0]             clr_ff, clr_in;
   logic [IW-1:0]             iter_ff, iter_in;
   logic [WC-1:0]             wcount_ff, wcount_in;
   logic [TC-1:0]             tcount_ff, tcount_in;
   logic                      rd_ok_ff, rd_ok_in;
   logic [GRID_W-1:0]         src_grid_ff, src_grid_in;
   logic [GRID_W-1:0]         dst_grid_ff, dst_grid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;

   logic                      accept;
   logic                      range_bad;
   logic                      table_full;

   tbl_ctl_type               tbl_ctl;
   logic [IDX_W-1:0]          tbl_rd_src;
   logic [IDX_W-1:0]          tbl_rd_dst;
   logic signed [DATA_W-1:0]  tbl_rd_weight;
   logic [IDX_W-1:0]          touch_rd_dst;

   logic signed [DATA_W-1:0]  src_mem [SRC_CELLS];
   logic signed [DATA_W-1:0]  dst_mem [DST_CELLS];
   logic                      src_we;
   logic [SA-1:0]             src_waddr;
   logic signed [DATA_W-1:0]  src_wdata;
   logic signed [DATA_W-1:0]  src_rd_ff;
   logic                      dst_we;
   logic [DA-1:0]             dst_waddr;
   logic [DA-1:0]             dst_raddr;
   logic signed [DATA_W-1:0]  dst_wdata;
   logic signed [DATA_W-1:0]  dst_rd_ff;

   logic                      src_ok;
   logic                      dst_ok;
   logic                      mac_load;
   logic signed [DATA_W-1:0]  mac_sample;
   logic signed [DATA_W-1:0]  mac_sum;

   assign req_stall = !(state_ff == ST_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_weight_total = rsp_total_ff;

   assign range_bad = req_checked && ({1'b0, req_src_cell} >= src_grid_ff ||
                                      {1'b0, req_dst_cell} >= dst_grid_ff);
   assign table_full = (wcount_ff == WC'(MAX_WEIGHTS)) ||
                       (req_opens_destination && tcount_ff == TC'(TOUCHED_MAX));

   // Source entries beyond the memory read as zero; entries beyond either memory are never written.
   assign src_ok     = 32'(tbl_rd_src) < 32'(SRC_CELLS);
   assign dst_ok     = 32'(tbl_rd_dst) < 32'(DST_CELLS);
   assign mac_sample = src_ok ? src_rd_ff : '0;
   assign dst_raddr  = (state_ff == ST_IDLE) ? DA'(req_dst_cell) : DA'(tbl_rd_dst);

   srmv_wtable #(
      .MAX_WEIGHTS (MAX_WEIGHTS),
      .TOUCHED_MAX (TOUCHED_MAX)
   ) u_wtable (
      .clock         (clock),
      .ctl           (tbl_ctl),
      .wr_addr       (WA'(wcount_ff)),
      .touch_wr_addr (TA'(tcount_ff)),
      .wr_src        (req_src_cell),
      .wr_dst        (req_dst_cell),
      .wr_weight     (req_weight),
      .rd_addr       (WA'(iter_ff)),
      .touch_rd_addr (TA'(iter_ff)),
      .rd_src        (tbl_rd_src),
      .rd_dst        (tbl_rd_dst),
      .rd_weight     (tbl_rd_weight),
      .touch_rd_dst  (touch_rd_dst)
   );

   srmv_mac u_mac (
      .clock  (clock),
      .load   (mac_load),
      .sample (mac_sample),
      .weight (tbl_rd_weight),
      .acc    (dst_rd_ff),
      .sum    (mac_sum)
   );

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= src_wdata;
      end
      src_rd_ff <= src_mem[SA'(tbl_rd_src)];
   end

   always_ff @(posedge clock) begin
      if (dst_we) begin
         dst_mem[dst_waddr] <= dst_wdata;
      end
      dst_rd_ff <= dst_mem[dst_raddr];
   end

   always_comb begin
      src_grid_in = src_grid_ff;
      dst_grid_in = dst_grid_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SRC_GRID: src_grid_in = csr_wdata;
            CSR_DST_GRID: dst_grid_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      iter_in       = iter_ff;
      wcount_in     = wcount_ff;
      tcount_in     = tcount_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      src_we        = 1'b0;
      src_waddr     = SA'(req_src_cell);
      src_wdata     = req_sample;
      dst_we        = 1'b0;
      dst_waddr     = DA'(tbl_rd_dst);
      dst_wdata     = mac_sum;
      tbl_ctl       = '0;
      mac_load      = 1'b0;

      case (state_ff)
         ST_INIT: begin
            src_we    = 32'(clr_ff) < 32'(SRC_CELLS);
            src_waddr = SA'(clr_ff);
            src_wdata = '0;
            dst_we    = 32'(clr_ff) < 32'(DST_CELLS);
            dst_waddr = DA'(clr_ff);
            dst_wdata = '0;
            if (clr_ff == CA'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_status_in = STATUS_OK;
               rsp_total_in  = TOTAL_W'(wcount_ff);
               case (req_mode)
                  MODE_CLEAR: begin
                     wcount_in    = '0;
                     tcount_in    = '0;
                     rsp_total_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (range_bad) begin
                        rsp_status_in = STATUS_RANGE;
                     end else if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        tbl_ctl.wr_weight = 1'b1;
                        tbl_ctl.wr_touch  = req_opens_destination;
                        wcount_in         = wcount_ff + 1'b1;
                        tcount_in         = tcount_ff + TC'(req_opens_destination);
                        rsp_total_in      = TOTAL_W'(wcount_ff + 1'b1);
                     end
                  end
                  MODE_SRC: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_src_cell) < 32'(SRC_CELLS)) begin
                        src_we = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  MODE_RUN: begin
                     iter_in  = '0;
                     state_in = ST_ZERO_ISSUE;
                  end
                  MODE_READ: begin
                     rd_ok_in = 32'(req_dst_cell) < 32'(DST_CELLS);
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_ok_ff ? dst_rd_ff : '0;
            rsp_status_in = rd_ok_ff ? STATUS_OK : STATUS_RANGE;
            state_in      = ST_IDLE;
         end
         ST_ZERO_ISSUE: begin
            if (iter_ff < IW'(tcount_ff)) begin
               state_in = ST_ZERO_WR;
            end else begin
               iter_in  = '0;
               state_in = ST_W_ISSUE;
            end
         end
         ST_ZERO_WR: begin
            dst_we    = 32'(touch_rd_dst) < 32'(DST_CELLS);
            dst_waddr = DA'(touch_rd_dst);
            dst_wdata = '0;
            iter_in   = iter_ff + 1'b1;
            state_in  = ST_ZERO_ISSUE;
         end
         ST_W_ISSUE: begin
            if (iter_ff < IW'(wcount_ff)) begin
               state_in = ST_W_FETCH;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_W_FETCH: begin
            state_in = ST_W_MUL;
         end
         ST_W_MUL: begin
            mac_load = 1'b1;
            state_in = ST_W_ACC;
         end
         ST_W_ACC: begin
            dst_we   = dst_ok;
            iter_in  = iter_ff + 1'b1;
            state_in = ST_W_ISSUE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         iter_ff      <= '0;
         wcount_ff    <= '0;
         tcount_ff    <= '0;
         rd_ok_ff     <= 1'b0;
         src_grid_ff  <= GRID_RESET;
         dst_grid_ff  <= GRID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         iter_ff      <= iter_in;
         wcount_ff    <= wcount_in;
         tcount_ff    <= tcount_in;
         rd_ok_ff     <= rd_ok_in;
         src_grid_ff  <= src_grid_in;
         dst_grid_ff  <= dst_grid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule
